FILE: sv/cpsrq_pkg.sv
`default_nettype none
package cpsrq_pkg;

  localparam int MAX_POINTS  = 256;
  localparam int WEIGHT_BITS = 32;

  localparam int IDX_W   = $clog2(MAX_POINTS);
  localparam int CNT_W   = IDX_W + 1;
  localparam int TAB_AW  = 2 * IDX_W;
  localparam int TIME_W  = 16;
  localparam int DIST_W  = 24;
  localparam int WGT_W   = 32;
  localparam int SUM_W   = 48;
  localparam int KEY_W   = DIST_W + 2;
  localparam int WEXT_W  = (WEIGHT_BITS < WGT_W) ? WEIGHT_BITS : WGT_W;
  localparam int STAT_W  = 2;
  localparam int TDATA_W = 160;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_NOSET = 2'd1,
    ST_DROP  = 2'd2
  } res_status_e;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LATCH,
    OP_LOAD,
    OP_SORT_INIT,
    OP_SORT_RD,
    OP_SORT_CMP,
    OP_SORT_END,
    OP_CLR,
    OP_ACC_RD,
    OP_ACC_KEY,
    OP_SRCH_RD,
    OP_SRCH_CMP,
    OP_ACC_TRD,
    OP_ACC_WR,
    OP_PFX_RD0,
    OP_PFX_RD1,
    OP_PFX_WR,
    OP_Q_KEY_LO,
    OP_Q_KEY_HI,
    OP_Q_SUM,
    OP_Q_R0,
    OP_Q_R1,
    OP_Q_R2,
    OP_Q_R3,
    OP_Q_R4
  } dp_op_e;

  typedef struct packed {
    dp_op_e      op;
    logic        out_load;
    res_status_e out_code;
    logic        out_zero;
  } dp_cmd_t;

  typedef struct packed {
    logic is_query;
    logic last_pt;
    logic built;
    logic drop_now;
    logic sort_last;
    logic any_found;
    logic grid_last;
    logic acc_last;
    logic srch_done;
    logic q_empty;
    logic out_free;
  } dp_stat_t;

  typedef struct packed {
    logic                    operation;
    logic [TIME_W-1:0]       point_time;
    logic [DIST_W-1:0]       point_dist;
    logic signed [WGT_W-1:0] point_weight;
    logic                    last_point;
    logic [TIME_W-1:0]       query_time_low;
    logic [TIME_W-1:0]       query_time_high;
    logic [DIST_W-1:0]       query_dist_low;
    logic [DIST_W-1:0]       query_dist_high;
    logic                    from_left;
  } item_t;

endpackage
`default_nettype wire

FILE: sv/cpsrq_ctrl.sv
`default_nettype none
module cpsrq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cpsrq_pkg::dp_stat_t stat_i,
  output cpsrq_pkg::dp_cmd_t  cmd_o
);
  import cpsrq_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_SORT_INIT, S_SORT_RD, S_SORT_CMP, S_SORT_END, S_CLR,
    S_ACC_RD, S_ACC_KEY, S_SRCH_RD, S_SRCH_CMP, S_ACC_TRD, S_ACC_WR,
    S_PFX_RD0, S_PFX_RD1, S_PFX_WR, S_Q_KEY_HI, S_Q_SUM,
    S_Q_R0, S_Q_R1, S_Q_R2, S_Q_R3, S_Q_R4, S_RESULT
  } state_e;

  state_e      state_q, state_d, ret_q, ret_d;
  logic        drop_pend_q, drop_pend_d;
  res_status_e res_code_q, res_code_d;
  logic        res_zero_q, res_zero_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    drop_pend_d = drop_pend_q;
    res_code_d  = res_code_q;
    res_zero_d  = res_zero_q;
    cmd_o.op       = OP_NOP;
    cmd_o.out_load = 1'b0;
    cmd_o.out_code = res_code_q;
    cmd_o.out_zero = res_zero_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LATCH;
          state_d  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat_i.is_query) begin
          if (stat_i.built) begin
            cmd_o.op = OP_Q_KEY_LO;
            ret_d    = S_Q_KEY_HI;
            state_d  = S_SRCH_RD;
          end else begin
            res_code_d = ST_NOSET;
            res_zero_d = 1'b1;
            state_d    = S_RESULT;
          end
        end else begin
          cmd_o.op    = OP_LOAD;
          drop_pend_d = stat_i.drop_now;
          res_code_d  = ST_DROP;
          res_zero_d  = 1'b1;
          priority if (stat_i.last_pt) state_d = S_SORT_INIT;
          else if (stat_i.drop_now)    state_d = S_RESULT;
          else                         state_d = S_IDLE;
        end
      end
      S_SORT_INIT: begin
        cmd_o.op = OP_SORT_INIT;
        state_d  = S_SORT_RD;
      end
      S_SORT_RD: begin
        cmd_o.op = OP_SORT_RD;
        state_d  = S_SORT_CMP;
      end
      S_SORT_CMP: begin
        cmd_o.op = OP_SORT_CMP;
        state_d  = stat_i.sort_last ? S_SORT_END : S_SORT_RD;
      end
      S_SORT_END: begin
        cmd_o.op = OP_SORT_END;
        state_d  = stat_i.any_found ? S_SORT_RD : S_CLR;
      end
      S_CLR: begin
        cmd_o.op = OP_CLR;
        if (stat_i.grid_last) state_d = S_ACC_RD;
      end
      S_ACC_RD: begin
        cmd_o.op = OP_ACC_RD;
        state_d  = S_ACC_KEY;
      end
      S_ACC_KEY: begin
        cmd_o.op = OP_ACC_KEY;
        ret_d    = S_ACC_TRD;
        state_d  = S_SRCH_RD;
      end
      S_SRCH_RD: begin
        cmd_o.op = OP_SRCH_RD;
        state_d  = stat_i.srch_done ? ret_q : S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        cmd_o.op = OP_SRCH_CMP;
        state_d  = S_SRCH_RD;
      end
      S_ACC_TRD: begin
        cmd_o.op = OP_ACC_TRD;
        state_d  = S_ACC_WR;
      end
      S_ACC_WR: begin
        cmd_o.op = OP_ACC_WR;
        state_d  = stat_i.acc_last ? S_PFX_RD0 : S_ACC_RD;
      end
      S_PFX_RD0: begin
        cmd_o.op = OP_PFX_RD0;
        state_d  = S_PFX_RD1;
      end
      S_PFX_RD1: begin
        cmd_o.op = OP_PFX_RD1;
        state_d  = S_PFX_WR;
      end
      S_PFX_WR: begin
        cmd_o.op = OP_PFX_WR;
        priority if (!stat_i.grid_last) state_d = S_PFX_RD0;
        else if (drop_pend_q)           state_d = S_RESULT;
        else                            state_d = S_IDLE;
      end
      S_Q_KEY_HI: begin
        cmd_o.op = OP_Q_KEY_HI;
        ret_d    = S_Q_SUM;
        state_d  = S_SRCH_RD;
      end
      S_Q_SUM: begin
        cmd_o.op   = OP_Q_SUM;
        res_code_d = ST_OK;
        res_zero_d = stat_i.q_empty;
        state_d    = stat_i.q_empty ? S_RESULT : S_Q_R0;
      end
      S_Q_R0: begin
        cmd_o.op = OP_Q_R0;
        state_d  = S_Q_R1;
      end
      S_Q_R1: begin
        cmd_o.op = OP_Q_R1;
        state_d  = S_Q_R2;
      end
      S_Q_R2: begin
        cmd_o.op = OP_Q_R2;
        state_d  = S_Q_R3;
      end
      S_Q_R3: begin
        cmd_o.op = OP_Q_R3;
        state_d  = S_Q_R4;
      end
      S_Q_R4: begin
        cmd_o.op = OP_Q_R4;
        state_d  = S_RESULT;
      end
      S_RESULT: begin
        cmd_o.out_load = stat_i.out_free;
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      drop_pend_q <= 1'b0;
      res_code_q  <= ST_OK;
      res_zero_q  <= 1'b1;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      drop_pend_q <= drop_pend_d;
      res_code_q  <= res_code_d;
      res_zero_q  <= res_zero_d;
    end
  end

endmodule
`default_nettype wire

FILE: sv/cpsrq_datapath.sv
`default_nettype none
module cpsrq_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  cpsrq_pkg::dp_cmd_t                  cmd_i,
  input  cpsrq_pkg::item_t                    item_i,
  input  logic [cpsrq_pkg::DIST_W-1:0]        edge_length_i,
  output cpsrq_pkg::dp_stat_t                 stat_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [cpsrq_pkg::SUM_W-1:0]         range_sum_o,
  output logic [cpsrq_pkg::STAT_W-1:0]        status_o
);
  import cpsrq_pkg::*;

  // point store, sorted axes and prefix table
  logic [TIME_W-1:0] st_mem [MAX_POINTS];
  logic [DIST_W-1:0] sd_mem [MAX_POINTS];
  logic [WGT_W-1:0]  sw_mem [MAX_POINTS];
  logic [TIME_W-1:0] ta_mem [MAX_POINTS];
  logic [DIST_W-1:0] da_mem [MAX_POINTS];
  logic [SUM_W-1:0]  tab_mem [2**TAB_AW];

  logic [TIME_W-1:0] st_rd, ta_rd;
  logic [DIST_W-1:0] sd_rd, da_rd;
  logic [WGT_W-1:0]  sw_rd;
  logic [SUM_W-1:0]  tab_rd;

  item_t item_q;
  logic [CNT_W-1:0] cnt_q, nt_q, nd_q, p_q;
  logic             built_q;
  logic [IDX_W-1:0] i_q, j_q;
  logic [TIME_W-1:0] prev_t_q, min_t_q;
  logic [DIST_W-1:0] prev_d_q, min_d_q;
  logic             fnd_t_q, fnd_d_q, have_prev_q;
  logic [CNT_W-1:0] tlo_q, thi_q, dlo_q, dhi_q, t1_q, d1_q;
  logic [IDX_W-1:0] t2_q, d2_q;
  logic [TIME_W-1:0] tkey_q;
  logic signed [KEY_W-1:0] dkey_q;
  logic             le_q;
  logic [SUM_W-1:0] w_q, acc_q, row_q;
  logic             out_valid_q;
  logic [SUM_W-1:0] out_sum_q;
  logic [STAT_W-1:0] out_stat_q;

  logic [CNT_W-1:0] eff_cnt;
  logic             drop_now, j_end, i_end;
  logic [CNT_W:0]   sum_t, sum_d;
  logic [CNT_W-1:0] mid_t, mid_d;
  logic             t_better, d_better, t_go, d_go;
  logic             t_hit, d_hit;
  logic signed [KEY_W-1:0] da_key, edge_s, key_lo, key_hi;
  logic [IDX_W-1:0] t1m, d1m, i_m1;
  logic [TAB_AW-1:0] tab_raddr, tab_waddr;
  logic             tab_we;
  logic [SUM_W-1:0] tab_wdata, w_ext, row_d;

  assign eff_cnt  = built_q ? '0 : cnt_q;
  assign drop_now = (eff_cnt == CNT_W'(MAX_POINTS));
  assign j_end    = ({1'b0, j_q} == nd_q - 1'b1);
  assign i_end    = ({1'b0, i_q} == nt_q - 1'b1);
  assign sum_t    = {1'b0, tlo_q} + {1'b0, thi_q};
  assign sum_d    = {1'b0, dlo_q} + {1'b0, dhi_q};
  assign mid_t    = sum_t[CNT_W:1];
  assign mid_d    = sum_d[CNT_W:1];
  assign t_go     = tlo_q < thi_q;
  assign d_go     = dlo_q < dhi_q;
  assign t_hit    = le_q ? (ta_rd <= tkey_q) : (ta_rd < tkey_q);
  assign da_key   = $signed({2'b00, da_rd});
  assign d_hit    = le_q ? (da_key <= dkey_q) : (da_key < dkey_q);
  assign t_better = (!have_prev_q || st_rd > prev_t_q) && (!fnd_t_q || st_rd < min_t_q);
  assign d_better = (!have_prev_q || sd_rd > prev_d_q) && (!fnd_d_q || sd_rd < min_d_q);
  assign edge_s   = $signed({2'b00, edge_length_i});
  assign key_lo   = item_q.from_left ? $signed({2'b00, item_q.query_dist_low})
                                     : edge_s - $signed({2'b00, item_q.query_dist_high});
  assign key_hi   = item_q.from_left ? $signed({2'b00, item_q.query_dist_high})
                                     : edge_s - $signed({2'b00, item_q.query_dist_low});
  assign t1m      = IDX_W'(t1_q - 1'b1);
  assign d1m      = IDX_W'(d1_q - 1'b1);
  assign i_m1     = i_q - 1'b1;
  assign w_ext    = {{(SUM_W-WEXT_W){sw_rd[WEXT_W-1]}}, sw_rd[WEXT_W-1:0]};
  assign row_d    = row_q + tab_rd;

  // table port selection
  always_comb begin
    tab_raddr = {i_q, j_q};
    tab_waddr = {i_q, j_q};
    tab_we    = 1'b0;
    tab_wdata = '0;
    unique case (cmd_i.op)
      OP_CLR: tab_we = 1'b1;
      OP_ACC_TRD: tab_raddr = {tlo_q[IDX_W-1:0], dlo_q[IDX_W-1:0]};
      OP_ACC_WR: begin
        tab_waddr = {tlo_q[IDX_W-1:0], dlo_q[IDX_W-1:0]};
        tab_we    = 1'b1;
        tab_wdata = tab_rd + w_q;
      end
      OP_PFX_RD1: tab_raddr = {i_m1, j_q};
      OP_PFX_WR: begin
        tab_we    = 1'b1;
        tab_wdata = row_q + ((i_q != '0) ? tab_rd : '0);
      end
      OP_Q_R0: tab_raddr = {t2_q, d2_q};
      OP_Q_R1: tab_raddr = {t2_q, d1m};
      OP_Q_R2: tab_raddr = {t1m, d2_q};
      OP_Q_R3: tab_raddr = {t1m, d1m};
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (tab_we) tab_mem[tab_waddr] <= tab_wdata;
    tab_rd <= tab_mem[tab_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD && !drop_now) begin
      st_mem[eff_cnt[IDX_W-1:0]] <= item_q.point_time;
      sd_mem[eff_cnt[IDX_W-1:0]] <= item_q.point_dist;
      sw_mem[eff_cnt[IDX_W-1:0]] <= item_q.point_weight;
    end
    st_rd <= st_mem[p_q[IDX_W-1:0]];
    sd_rd <= sd_mem[p_q[IDX_W-1:0]];
    sw_rd <= sw_mem[p_q[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_SORT_END && fnd_t_q) ta_mem[nt_q[IDX_W-1:0]] <= min_t_q;
    if (cmd_i.op == OP_SORT_END && fnd_d_q) da_mem[nd_q[IDX_W-1:0]] <= min_d_q;
    ta_rd <= ta_mem[mid_t[IDX_W-1:0]];
    da_rd <= da_mem[mid_d[IDX_W-1:0]];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      nt_q        <= '0;
      nd_q        <= '0;
      built_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (cmd_i.op)
        OP_LOAD: begin
          built_q <= 1'b0;
          cnt_q   <= drop_now ? eff_cnt : eff_cnt + 1'b1;
        end
        OP_SORT_INIT: begin
          nt_q <= '0;
          nd_q <= '0;
        end
        OP_SORT_END: begin
          if (fnd_t_q) nt_q <= nt_q + 1'b1;
          if (fnd_d_q) nd_q <= nd_q + 1'b1;
        end
        OP_PFX_WR: if (i_end && j_end) built_q <= 1'b1;
        default: ;
      endcase
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LATCH: item_q <= item_i;
      OP_SORT_INIT: begin
        p_q         <= '0;
        fnd_t_q     <= 1'b0;
        fnd_d_q     <= 1'b0;
        have_prev_q <= 1'b0;
      end
      OP_SORT_RD: ;
      OP_SORT_CMP: begin
        if (t_better) begin
          min_t_q <= st_rd;
          fnd_t_q <= 1'b1;
        end
        if (d_better) begin
          min_d_q <= sd_rd;
          fnd_d_q <= 1'b1;
        end
        p_q <= p_q + 1'b1;
      end
      OP_SORT_END: begin
        if (fnd_t_q) prev_t_q <= min_t_q;
        if (fnd_d_q) prev_d_q <= min_d_q;
        have_prev_q <= 1'b1;
        fnd_t_q     <= 1'b0;
        fnd_d_q     <= 1'b0;
        p_q         <= '0;
        i_q         <= '0;
        j_q         <= '0;
      end
      OP_CLR: begin
        j_q <= j_end ? '0 : j_q + 1'b1;
        if (j_end) i_q <= i_q + 1'b1;
        p_q <= '0;
      end
      OP_ACC_KEY: begin
        tkey_q <= st_rd;
        dkey_q <= $signed({2'b00, sd_rd});
        le_q   <= 1'b0;
        w_q    <= w_ext;
        tlo_q  <= '0;
        thi_q  <= nt_q;
        dlo_q  <= '0;
        dhi_q  <= nd_q;
      end
      OP_SRCH_CMP: begin
        if (t_go) begin
          if (t_hit) tlo_q <= mid_t + 1'b1;
          else       thi_q <= mid_t;
        end
        if (d_go) begin
          if (d_hit) dlo_q <= mid_d + 1'b1;
          else       dhi_q <= mid_d;
        end
      end
      OP_ACC_WR: begin
        p_q   <= p_q + 1'b1;
        i_q   <= '0;
        j_q   <= '0;
        row_q <= '0;
      end
      OP_PFX_RD1: row_q <= row_d;
      OP_PFX_WR: begin
        j_q <= j_end ? '0 : j_q + 1'b1;
        if (j_end) begin
          i_q   <= i_q + 1'b1;
          row_q <= '0;
        end
      end
      OP_Q_KEY_LO: begin
        tkey_q <= item_q.query_time_low;
        dkey_q <= key_lo;
        le_q   <= 1'b0;
        tlo_q  <= '0;
        thi_q  <= nt_q;
        dlo_q  <= '0;
        dhi_q  <= nd_q;
      end
      OP_Q_KEY_HI: begin
        t1_q   <= tlo_q;
        d1_q   <= dlo_q;
        tkey_q <= item_q.query_time_high;
        dkey_q <= key_hi;
        le_q   <= 1'b1;
        tlo_q  <= '0;
        thi_q  <= nt_q;
        dlo_q  <= '0;
        dhi_q  <= nd_q;
      end
      OP_Q_SUM: begin
        t2_q  <= IDX_W'(tlo_q - 1'b1);
        d2_q  <= IDX_W'(dlo_q - 1'b1);
        acc_q <= '0;
      end
      OP_Q_R1: acc_q <= tab_rd;
      OP_Q_R2: if (d1_q != '0) acc_q <= acc_q - tab_rd;
      OP_Q_R3: if (t1_q != '0) acc_q <= acc_q - tab_rd;
      OP_Q_R4: if (t1_q != '0 && d1_q != '0) acc_q <= acc_q + tab_rd;
      default: ;
    endcase
    if (cmd_i.out_load) begin
      out_sum_q  <= cmd_i.out_zero ? '0 : acc_q;
      out_stat_q <= cmd_i.out_code;
    end
  end

  assign stat_o.is_query  = item_q.operation;
  assign stat_o.last_pt   = item_q.last_point;
  assign stat_o.built     = built_q;
  assign stat_o.drop_now  = drop_now;
  assign stat_o.sort_last = (p_q == cnt_q - 1'b1);
  assign stat_o.any_found = fnd_t_q | fnd_d_q;
  assign stat_o.grid_last = i_end && j_end;
  assign stat_o.acc_last  = (p_q == cnt_q - 1'b1);
  assign stat_o.srch_done = !t_go && !d_go;
  assign stat_o.q_empty   = (tlo_q <= t1_q) || (dlo_q <= d1_q);
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign range_sum_o = out_sum_q;
  assign status_o    = out_stat_q;

endmodule
`default_nettype wire

FILE: sv/compressed_prefix_sum_range_query_core.sv
// Two-dimensional prefix-sum range query over weighted points on one edge.
// Input stream (s_axis): tuser selects the operation (0 load point, 1 query);
// tlast on a load closes the point set and starts the table build.
// Output stream (m_axis): one item per query and per dropped load, carrying
// the 48-bit range sum and a 2-bit status (ok, no built set, store full).
// APB port: register 0 at byte address 0 holds edge_length (Q16.8), used to
// mirror distances for queries measured from the edge end.
// A query runs two binary searches, one for the low and one for the high
// bounds, each step shared by the two axis memories, and then four
// prefix-table reads. A build runs a selection sort of the distinct values
// on each axis, clears every table cell, adds each point's weight into its
// cell, found by a search on each axis, and then makes a prefix pass.
// Reset clears the point count, axis counts, built flag and edge_length; the
// memories need no clearing. A result waits in an output register while the
// receiver stalls; the next item is still taken, and the block stalls only
// when a further result is ready with the register still full.
`default_nettype none
module compressed_prefix_sum_range_query_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [15:0] point_time, [39:16] point_dist, [71:40] point_weight,
  // [87:72] query_time_low, [103:88] query_time_high,
  // [127:104] query_dist_low, [151:128] query_dist_high, [152] from_left
  input  logic [cpsrq_pkg::TDATA_W-1:0]   s_axis_tdata,
  input  logic                            s_axis_tlast,
  // [0] operation
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [47:0] range_sum
  output logic [cpsrq_pkg::SUM_W-1:0]     m_axis_tdata,
  // [1:0] status
  output logic [cpsrq_pkg::STAT_W-1:0]    m_axis_tuser,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import cpsrq_pkg::*;

  localparam logic REG_EDGE = 1'b0;

  logic [DIST_W-1:0] edge_q;
  item_t             item;
  dp_cmd_t           cmd;
  dp_stat_t          stat;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_EDGE);
  assign prdata = (paddr[2] == REG_EDGE) ? {8'h00, edge_q} : '0;

  // hold edge length until rewritten
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_q <= '0;
    end else if (cfg_wr) begin
      edge_q <= pwdata[DIST_W-1:0];
    end
  end

  // unpack the input item
  assign item.operation       = s_axis_tuser;
  assign item.point_time      = s_axis_tdata[15:0];
  assign item.point_dist      = s_axis_tdata[39:16];
  assign item.point_weight    = s_axis_tdata[71:40];
  assign item.last_point      = s_axis_tlast;
  assign item.query_time_low  = s_axis_tdata[87:72];
  assign item.query_time_high = s_axis_tdata[103:88];
  assign item.query_dist_low  = s_axis_tdata[127:104];
  assign item.query_dist_high = s_axis_tdata[151:128];
  assign item.from_left       = s_axis_tdata[152];

  cpsrq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  cpsrq_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .item_i        (item),
    .edge_length_i (edge_q),
    .stat_o        (stat),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .range_sum_o   (m_axis_tdata),
    .status_o      (m_axis_tuser)
  );

endmodule
`default_nettype wire

FILE: tb/tb_compressed_prefix_sum_range_query_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Tracks the point set and the built table state and holds the expected
// range sums in order of arrival.
class range_sum_board;
  typedef struct {
    logic [cpsrq_pkg::SUM_W-1:0] sum;
    cpsrq_pkg::res_status_e      status;
  } sum_entry_t;

  logic [15:0]        pt_time[$];
  logic [23:0]        pt_dist[$];
  logic signed [31:0] pt_wgt[$];
  bit                 built;
  logic [23:0]        edge_len;
  sum_entry_t         sums_due[$];
  int                 errors;
  int                 seen;

  function new();
    built = 0;
    edge_len = '0;
    errors = 0;
    seen = 0;
  endfunction

  function void note_item(cpsrq_pkg::item_t it);
    sum_entry_t e;
    bit dropped;
    longint lo, hi, d;
    logic [63:0] acc;
    dropped = 0;
    if (it.operation == 1'b0) begin
      if (built) begin
        pt_time.delete();
        pt_dist.delete();
        pt_wgt.delete();
        built = 0;
      end
      if (pt_time.size() < cpsrq_pkg::MAX_POINTS) begin
        pt_time.insert(pt_time.size(), it.point_time);
        pt_dist.insert(pt_dist.size(), it.point_dist);
        pt_wgt.insert(pt_wgt.size(), it.point_weight);
      end else begin
        dropped = 1;
      end
      if (it.last_point) built = 1;
      if (dropped) begin
        e.sum = '0;
        e.status = cpsrq_pkg::ST_DROP;
        sums_due.insert(sums_due.size(), e);
      end
    end else if (!built) begin
      e.sum = '0;
      e.status = cpsrq_pkg::ST_NOSET;
      sums_due.insert(sums_due.size(), e);
    end else begin
      if (it.from_left) begin
        lo = it.query_dist_low;
        hi = it.query_dist_high;
      end else begin
        lo = longint'(edge_len) - longint'(it.query_dist_high);
        hi = longint'(edge_len) - longint'(it.query_dist_low);
      end
      acc = '0;
      foreach (pt_time[k]) begin
        d = pt_dist[k];
        if (pt_time[k] >= it.query_time_low && pt_time[k] <= it.query_time_high &&
            d >= lo && d <= hi)
          acc = acc + {{32{pt_wgt[k][31]}}, pt_wgt[k]};
      end
      e.sum = acc[cpsrq_pkg::SUM_W-1:0];
      e.status = cpsrq_pkg::ST_OK;
      sums_due.insert(sums_due.size(), e);
    end
  endfunction

  function void check_result(logic [cpsrq_pkg::SUM_W-1:0] sum, logic [1:0] status);
    sum_entry_t e;
    seen++;
    if (sums_due.size() == 0) begin
      $error("unexpected result: range_sum %0h status %0d", sum, status);
      errors++;
      return;
    end
    e = sums_due.pop_front();
    if (sum !== e.sum) begin
      $error("range_sum: expected %0h, got %0h", e.sum, sum);
      errors++;
    end
    if (status !== e.status) begin
      $error("status: expected %0d, got %0d", e.status, status);
      errors++;
    end
  endfunction
endclass

module tb_compressed_prefix_sum_range_query_core;
  import cpsrq_pkg::item_t;

  localparam logic OPER_LOAD  = 1'b0;
  localparam logic OPER_QUERY = 1'b1;
  localparam logic [2:0] REG_EDGE_LENGTH = 3'd0;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [cpsrq_pkg::TDATA_W-1:0]    s_axis_tdata = '0;
  logic                             s_axis_tlast = 1'b0;
  logic                             s_axis_tuser = 1'b0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [cpsrq_pkg::SUM_W-1:0]      m_axis_tdata;
  logic [cpsrq_pkg::STAT_W-1:0]     m_axis_tuser;
  logic                             psel = 1'b0;
  logic                             penable = 1'b0;
  logic                             pwrite = 1'b0;
  logic [2:0]                       paddr = '0;
  logic [31:0]                      pwdata = '0;
  logic [31:0]                      prdata;
  logic                             pready;

  range_sum_board board = new();

  // Generator's own view of the current set, used to aim query bounds.
  logic [15:0] set_time[$];
  logic [23:0] set_dist[$];
  logic [23:0] cur_edge = '0;
  int          burst_left = 0;

  always #4 clk_i = ~clk_i;

  compressed_prefix_sum_range_query_core dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  function automatic item_t mk_load(logic [15:0] t, logic [23:0] d, logic [31:0] w,
                                    logic last);
    item_t it;
    it.operation       = OPER_LOAD;
    it.point_time      = t;
    it.point_dist      = d;
    it.point_weight    = w;
    it.last_point      = last;
    // Query fields are don't-care on a load; toggle them anyway.
    it.query_time_low  = 16'($urandom);
    it.query_time_high = 16'($urandom);
    it.query_dist_low  = 24'($urandom);
    it.query_dist_high = 24'($urandom);
    it.from_left       = 1'($urandom);
    return it;
  endfunction

  function automatic item_t mk_query(logic [15:0] tl, logic [15:0] th, logic [23:0] dl,
                                     logic [23:0] dh, logic fl);
    item_t it;
    it.operation       = OPER_QUERY;
    it.point_time      = 16'($urandom);
    it.point_dist      = 24'($urandom);
    it.point_weight    = $urandom;
    it.last_point      = 1'($urandom);
    it.query_time_low  = tl;
    it.query_time_high = th;
    it.query_dist_low  = dl;
    it.query_dist_high = dh;
    it.from_left       = fl;
    return it;
  endfunction

  // Offer one item and hold it until accepted; then either keep the burst
  // going or drop tvalid for a random gap.
  task automatic send(item_t it);
    @(negedge clk_i);
    s_axis_tdata  = {7'b0, it.from_left, it.query_dist_high, it.query_dist_low,
                     it.query_time_high, it.query_time_low, it.point_weight,
                     it.point_dist, it.point_time};
    s_axis_tlast  = it.last_point;
    s_axis_tuser  = it.operation;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_item(it);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(0, 8);
    end
  endtask

  task automatic load_point(logic [15:0] t, logic [23:0] d, logic [31:0] w, logic last);
    if (board.built) begin
      set_time.delete();
      set_dist.delete();
    end
    if (set_time.size() < cpsrq_pkg::MAX_POINTS) begin
      set_time.insert(set_time.size(), t);
      set_dist.insert(set_dist.size(), d);
    end
    send(mk_load(t, d, w, last));
  endtask

  // Drop tvalid, wait until every expected result is back, then let any
  // build settle.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (board.sums_due.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_edge(logic [23:0] value);
    drain();
    @(negedge clk_i);
    psel   = 1'b1;
    pwrite = 1'b1;
    paddr  = REG_EDGE_LENGTH;
    pwdata = {8'h0, value};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    board.edge_len = value;
    cur_edge = value;
  endtask

  // Query aimed at the current set: bounds near stored points, sometimes
  // fully random, sometimes mirrored about the edge length.
  task automatic aimed_query();
    int a, b, n;
    logic [15:0] tl, th;
    logic [23:0] dl, dh;
    logic fl;
    n = set_time.size();
    fl = 1'($urandom);
    if (n == 0 || $urandom_range(0, 5) == 0) begin
      send(mk_query(16'($urandom), 16'($urandom), 24'($urandom), 24'($urandom), fl));
      return;
    end
    a = $urandom_range(0, n - 1);
    b = $urandom_range(0, n - 1);
    tl = 16'(set_time[a] - $urandom_range(0, 2));
    th = 16'(set_time[b] + $urandom_range(0, 2));
    dl = 24'(set_dist[a] - $urandom_range(0, 2));
    dh = 24'(set_dist[b] + $urandom_range(0, 2));
    if ($urandom_range(0, 3) == 0) begin
      tl = 16'h0;
      th = 16'hFFFF;
    end
    if (!fl) begin
      // Mirror the intended window so it hits the points from the far end.
      send(mk_query(tl, th, cur_edge - dh, cur_edge - dl, fl));
    end else begin
      send(mk_query(tl, th, dl, dh, fl));
    end
  endtask

  // One set: loads, usually with values from small pools to force duplicates on the
  // axes, then queries; sometimes a query slips in before the set is closed.
  task automatic random_set(int npts);
    logic [15:0] tpool[4];
    logic [23:0] dpool[4];
    bit wide;
    wide = ($urandom_range(0, 2) == 0);
    foreach (tpool[k]) tpool[k] = 16'($urandom);
    foreach (dpool[k]) dpool[k] = 24'($urandom);
    for (int k = 0; k < npts; k++) begin
      if ($urandom_range(0, 15) == 0) aimed_query();
      load_point(wide ? 16'($urandom) : tpool[$urandom_range(0, 3)],
                 wide ? 24'($urandom) : dpool[$urandom_range(0, 3)],
                 $urandom, k == npts - 1);
    end
    repeat ($urandom_range(4, 12)) aimed_query();
  endtask

  // Receiver: alternate ready stretches with stall patterns; once, hold off
  // for a long stretch so the block fills up and stalls its input.
  initial begin
    int stretch;
    bit stalling;
    bit held;
    held = 0;
    @(posedge rst_ni);
    forever begin
      stretch = $urandom_range(30, 200);
      stalling = 1'($urandom);
      repeat (stretch) begin
        @(negedge clk_i);
        if (!held && board.seen >= 40) begin
          held = 1;
          m_axis_tready = 1'b0;
          repeat (500) @(negedge clk_i);
        end
        m_axis_tready = stalling ? ($urandom_range(0, 2) == 0) : 1'b1;
      end
    end
  end

  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata, m_axis_tuser);

  initial begin
    #50_000_000;
    $display("compressed_prefix_sum_range_query_core: mismatch");
    $finish;
  end

  initial begin
    logic [23:0] edge_set[6];
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part.
    send(mk_query(16'h0, 16'hFFFF, 24'h0, 24'hFFFFFF, 1'b1));      // no set yet
    write_edge(24'h000200);
    load_point(16'h0000, 24'h000000, 32'h8000_0000, 1'b0);
    load_point(16'hFFFF, 24'hFFFFFF, 32'h7FFF_FFFF, 1'b0);
    load_point(16'h1234, 24'h000100, 32'hFFFF_FFFB, 1'b0);
    load_point(16'h1234, 24'h000100, 32'h0000_0009, 1'b0);         // duplicate point
    load_point(16'h8000, 24'h800000, 32'h0000_0001, 1'b1);
    send(mk_query(16'h0, 16'hFFFF, 24'h0, 24'hFFFFFF, 1'b1));
    send(mk_query(16'h0, 16'h0, 24'h0, 24'h0, 1'b1));
    send(mk_query(16'hFFFF, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1));
    send(mk_query(16'h1234, 16'h1234, 24'h000100, 24'h000100, 1'b1));
    send(mk_query(16'h2000, 16'h1000, 24'h0, 24'hFFFFFF, 1'b1));    // time low > high
    send(mk_query(16'h0, 16'hFFFF, 24'h900000, 24'h100, 1'b1));    // dist low > high
    send(mk_query(16'h0, 16'hFFFF, 24'h0, 24'hFFFFFF, 1'b0));       // mirrored, below zero
    send(mk_query(16'h0, 16'hFFFF, 24'h000100, 24'h000200, 1'b0));  // mirrored onto 0, 0x100
    send(mk_query(16'h0, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0));
    load_point(16'h0042, 24'h000042, 32'h0000_0003, 1'b1);         // load after build
    send(mk_query(16'h0, 16'hFFFF, 24'h0, 24'hFFFFFF, 1'b1));
    send(mk_query(16'h0043, 16'hFFFF, 24'h0, 24'hFFFFFF, 1'b1));
    drain();

    // Random part over several edge lengths, extremes included.
    edge_set = '{24'h000000, 24'hFFFFFF, 24'h001000, 24'h000000, 24'h7FFFFF, 24'hFFFFFF};
    edge_set[2] = 24'($urandom);
    foreach (edge_set[p]) begin
      write_edge(edge_set[p]);
      if (p == 3) begin
        // Fill the store, then two loads that get dropped; the second closes
        // the set and builds on what is stored.
        for (int k = 0; k < cpsrq_pkg::MAX_POINTS; k++)
          load_point(16'($urandom_range(0, 3) * 16'h4111), 24'($urandom_range(0, 3) << 22),
                     $urandom, 1'b0);
        load_point(16'($urandom), 24'($urandom), $urandom, 1'b0);
        load_point(16'($urandom), 24'($urandom), $urandom, 1'b1);
        repeat (10) aimed_query();
      end
      repeat (8) random_set($urandom_range(1, 10));
      drain();
    end

    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    drain();
    if (board.errors == 0) begin
      $display("compressed_prefix_sum_range_query_core: match");
    end else begin
      $display("compressed_prefix_sum_range_query_core: mismatch");
    end
    $finish;
  end
endmodule

`default_nettype wire
